### sv/pl0_pkg.sv
// ----------------------------------------------------------------------------
// PL/0 P-machine package
// Shared sizes, instruction codes, error codes, state and command types.
// ----------------------------------------------------------------------------
package pl0_pkg;

  // Sizes of the stack and the code space.
  localparam int STACK_DEPTH = 2048;
  localparam int SAW         = $clog2(STACK_DEPTH);
  localparam int CODE_DEPTH  = 512;
  localparam int PCW         = $clog2(CODE_DEPTH);
  localparam int MAX_LEVEL   = 7;
  localparam int LVLW        = 3;

  // Major opcodes.
  localparam logic [3:0] OP_LIT = 4'd0;
  localparam logic [3:0] OP_OPR = 4'd1;
  localparam logic [3:0] OP_LOD = 4'd2;
  localparam logic [3:0] OP_STO = 4'd3;
  localparam logic [3:0] OP_CAL = 4'd4;
  localparam logic [3:0] OP_INC = 4'd5;
  localparam logic [3:0] OP_JMP = 4'd6;
  localparam logic [3:0] OP_JPC = 4'd7;
  localparam logic [3:0] OP_SIO = 4'd8;

  // Sub-operations of OPR.
  localparam logic [3:0] OPR_RET = 4'd0;
  localparam logic [3:0] OPR_NEG = 4'd1;
  localparam logic [3:0] OPR_ADD = 4'd2;
  localparam logic [3:0] OPR_SUB = 4'd3;
  localparam logic [3:0] OPR_MUL = 4'd4;
  localparam logic [3:0] OPR_DIV = 4'd5;
  localparam logic [3:0] OPR_ODD = 4'd6;
  localparam logic [3:0] OPR_MOD = 4'd7;
  localparam logic [3:0] OPR_EQL = 4'd8;
  localparam logic [3:0] OPR_NEQ = 4'd9;
  localparam logic [3:0] OPR_LSS = 4'd10;
  localparam logic [3:0] OPR_LEQ = 4'd11;
  localparam logic [3:0] OPR_GTR = 4'd12;
  localparam logic [3:0] OPR_GEQ = 4'd13;

  // Sub-operations of SIO.
  localparam logic [3:0] SIO_WRITE = 4'd0;
  localparam logic [3:0] SIO_READ  = 4'd1;
  localparam logic [3:0] SIO_HALT  = 4'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_OPR   = 3'd1;
  localparam logic [2:0] ERR_SIO   = 3'd2;
  localparam logic [2:0] ERR_DIV0  = 3'd3;
  localparam logic [2:0] ERR_RANGE = 3'd4;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DEC, S_WALK, S_WALK_CK, S_LOD_W, S_STO_W,
    S_CAL2, S_CAL3, S_CAL4, S_RET1, S_RET2, S_NEG, S_ODD,
    S_B1, S_B2, S_ALU, S_DIV, S_WRB, S_JPC, S_SIO_W, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    A_SP, A_SPM1, A_SPP1, A_SPP2, A_SPP3, A_SPP4, A_BP2, A_BP3, A_LINK, A_EA, A_CLR
  } addr_sel_t;

  typedef enum logic [3:0] {
    WD_M, WD_INV, WD_ZERO, WD_B, WD_BP, WD_PC, WD_RES, WD_RD, WD_NEG, WD_ODD
  } wd_sel_t;

  typedef enum logic [2:0] {SP_HOLD, SP_INC, SP_DEC, SP_ADDM, SP_RET} sp_op_t;
  typedef enum logic [1:0] {PC_HOLD, PC_M, PC_X} pc_op_t;
  typedef enum logic [1:0] {BP_HOLD, BP_SPP1, BP_RD} bp_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    addr_sel_t  addr_sel;
    logic       mem_wr;
    wd_sel_t    wd_sel;
    sp_op_t     sp_op;
    pc_op_t     pc_op;
    bp_op_t     bp_op;
    logic       walk_init;
    logic       walk_step;
    logic       x_ld;
    logic       y_ld;
    logic       res_ld;
    logic       div_start;
    logic       res_div_ld;
    logic       err_ld;
    logic [2:0] err_code;
    logic       halt_ld;
    logic       out_set;
    logic       out_ld;
    logic       clr_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [3:0] op;
    logic [3:0] m_lo;
    logic       m_hi_zero;
    logic       sp_full;
    logic       sp_ge1;
    logic       sp_ge2;
    logic       sp4_ok;
    logic       ret_ok;
    logic       link_ok;
    logic       rd_ok;
    logic       ea_ok;
    logic       inc_ok;
    logic       rd_zero;
    logic       y_zero;
    logic       lvl_zero;
    logic       div_done;
    logic       out_free;
    logic       clr_last;
  } sts_t;

  // Two-operand ALU for add, subtract and the compares.
  function automatic logic [31:0] alu(input logic [3:0] sub, input logic [31:0] a,
                                      input logic [31:0] b);
    logic [31:0] r;
    r = '0;
    case (sub)
      OPR_ADD: r = a + b;
      OPR_SUB: r = a - b;
      OPR_EQL: r = {31'd0, a == b};
      OPR_NEQ: r = {31'd0, a != b};
      OPR_LSS: r = {31'd0, $signed(a) < $signed(b)};
      OPR_LEQ: r = {31'd0, $signed(a) <= $signed(b)};
      OPR_GTR: r = {31'd0, $signed(a) > $signed(b)};
      OPR_GEQ: r = {31'd0, $signed(a) >= $signed(b)};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### sv/pl0_stack_machine_execute.sv
// ----------------------------------------------------------------------------
// PL/0 P-machine execute unit
// Executes one P-machine instruction per input beat and returns one result.
// ----------------------------------------------------------------------------
//  channel  ports                                     beat
//  in       in_valid / in_stall                       op, level, operand, value
//  out      out_valid / out_stall                     next pc, output, halt, error
//
//  After reset a clearing pass zeroes the 2048-word stack with in_stall high.
//  A static link walk reads and checks one link per level, and div or mod
//  runs a bit-serial divider.
//  The single-port stack memory limits frame building to one word per cycle.
//  A finished beat waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
module pl0_stack_machine_execute import pl0_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_op,
  input  logic [2:0]         in_level,
  input  logic signed [31:0] in_operand,
  input  logic signed [31:0] in_in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [8:0]         out_next_pc,
  output logic               out_out_valid,
  output logic signed [31:0] out_out_value,
  output logic               out_halted,
  output logic [2:0]         out_error
);

  cmd_t cmd;
  sts_t sts;

  pl0_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pl0_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_op),
    .in_level      (in_level),
    .in_operand    (in_operand),
    .in_in_value   (in_in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_next_pc   (out_next_pc),
    .out_out_valid (out_out_valid),
    .out_out_value (out_out_value),
    .out_halted    (out_halted),
    .out_error     (out_error)
  );

  // One instruction at a time: the input closes right after a beat.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an instruction is in flight");

  // An output value is only produced by an error-free write.
  a_out_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_valid) |-> (out_error == ERR_NONE && !out_halted))
    else $error("output value together with an error or halt");

  // Halt comes only with a clean halt or a bad sio code.
  a_halt_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_halted) |-> (out_error == ERR_NONE || out_error == ERR_SIO))
    else $error("halt with an unexpected error code");

endmodule

### sv/pl0_div.sv
// ----------------------------------------------------------------------------
// PL/0 signed divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pl0_div import pl0_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] d_r;
  logic        negq_r;
  logic        negr_r;
  logic [32:0] sh;
  logic [32:0] diff;

  // One shift and trial subtract per cycle.
  assign sh   = {rem_r, quo_r[31]};
  assign diff = sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  // Magnitudes in, signs applied at the output.
  always_ff @(posedge clk) begin
    if (start) begin
      d_r    <= divisor[31] ? 32'd0 - divisor : divisor;
      quo_r  <= dividend[31] ? 32'd0 - dividend : dividend;
      rem_r  <= '0;
      negq_r <= dividend[31] ^ divisor[31];
      negr_r <= dividend[31];
    end else if (busy_r && cnt_r != 6'd0) begin
      if (!diff[32]) begin
        rem_r <= diff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= sh[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  assign done = busy_r && cnt_r == 6'd0;
  assign quo  = negq_r ? 32'd0 - quo_r : quo_r;
  assign rem  = negr_r ? 32'd0 - rem_r : rem_r;

endmodule

### sv/pl0_dp.sv
// ----------------------------------------------------------------------------
// PL/0 datapath
// Stack memory, machine registers, operand registers and the result stage.
// ----------------------------------------------------------------------------
module pl0_dp import pl0_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [3:0]         in_op,
  input  logic [2:0]         in_level,
  input  logic signed [31:0] in_operand,
  input  logic signed [31:0] in_in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [8:0]         out_next_pc,
  output logic               out_out_valid,
  output logic signed [31:0] out_out_value,
  output logic               out_halted,
  output logic [2:0]         out_error
);

  logic [31:0]     mem [STACK_DEPTH];
  logic [31:0]     rd_q;
  logic [SAW-1:0]  addr;
  logic [31:0]     wdata;

  logic [SAW-1:0]  sp_r, bp_r, b_r, clr_r;
  logic [PCW-1:0]  pc_r;
  logic [3:0]      op_r;
  logic [LVLW-1:0] lcnt_r;
  logic [31:0]     m_r, inv_r, x_r, y_r, res_r;
  logic            ov_r, halt_r;
  logic [31:0]     oval_r;
  logic [2:0]      err_r;
  logic            ofull_r;

  logic [32:0]     ea_sum, inc_sum;
  logic [SAW:0]    sp_p4, bp_p3;
  logic            div_done;
  logic [31:0]     div_quo, div_rem;

  pl0_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (x_r),
    .divisor  (y_r),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Address arithmetic and range checks.
  assign ea_sum  = {{(33-SAW){1'b0}}, b_r} + {m_r[31], m_r};
  assign inc_sum = {{(33-SAW){1'b0}}, sp_r} + {m_r[31], m_r};
  assign sp_p4   = {1'b0, sp_r} + (SAW+1)'(4);
  assign bp_p3   = {1'b0, bp_r} + (SAW+1)'(3);

  always_comb begin
    unique case (cmd.addr_sel)
      A_SP:    addr = sp_r;
      A_SPM1:  addr = sp_r - SAW'(1);
      A_SPP1:  addr = sp_r + SAW'(1);
      A_SPP2:  addr = sp_r + SAW'(2);
      A_SPP3:  addr = sp_r + SAW'(3);
      A_SPP4:  addr = sp_r + SAW'(4);
      A_BP2:   addr = bp_r + SAW'(2);
      A_BP3:   addr = bp_r + SAW'(3);
      A_LINK:  addr = b_r + SAW'(1);
      A_EA:    addr = ea_sum[SAW-1:0];
      A_CLR:   addr = clr_r;
      default: addr = sp_r;
    endcase
  end

  always_comb begin
    unique case (cmd.wd_sel)
      WD_M:    wdata = m_r;
      WD_INV:  wdata = inv_r;
      WD_ZERO: wdata = '0;
      WD_B:    wdata = {{(32-SAW){1'b0}}, b_r};
      WD_BP:   wdata = {{(32-SAW){1'b0}}, bp_r};
      WD_PC:   wdata = {{(32-PCW){1'b0}}, pc_r};
      WD_RES:  wdata = res_r;
      WD_RD:   wdata = rd_q;
      WD_NEG:  wdata = 32'd0 - rd_q;
      WD_ODD:  wdata = {31'd0, rd_q[0]};
      default: wdata = '0;
    endcase
  end

  // Single-port stack memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wdata;
    end
    rd_q <= mem[addr];
  end

  // Machine registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      bp_r  <= SAW'(1);
      pc_r  <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_r <= clr_r + SAW'(1);
      end
      if (cmd.accept) begin
        pc_r <= pc_r + PCW'(1);
      end else begin
        unique case (cmd.pc_op)
          PC_M:    pc_r <= m_r[PCW-1:0];
          PC_X:    pc_r <= x_r[PCW-1:0];
          default: pc_r <= pc_r;
        endcase
      end
      unique case (cmd.sp_op)
        SP_INC:  sp_r <= sp_r + SAW'(1);
        SP_DEC:  sp_r <= sp_r - SAW'(1);
        SP_ADDM: sp_r <= inc_sum[SAW-1:0];
        SP_RET:  sp_r <= bp_r - SAW'(1);
        default: sp_r <= sp_r;
      endcase
      unique case (cmd.bp_op)
        BP_SPP1: bp_r <= sp_r + SAW'(1);
        BP_RD:   bp_r <= rd_q[SAW-1:0];
        default: bp_r <= bp_r;
      endcase
    end
  end

  // Instruction fields, link walk and operand registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_op;
      m_r   <= in_operand;
      inv_r <= in_in_value;
    end
    if (cmd.walk_init) begin
      b_r    <= bp_r;
      lcnt_r <= (op_r == OP_LOD || op_r == OP_STO || op_r == OP_CAL) &&
                (in_level > LVLW'(MAX_LEVEL)) ? LVLW'(MAX_LEVEL) : lcnt_r;
    end else if (cmd.walk_step) begin
      b_r    <= rd_q[SAW-1:0];
      lcnt_r <= lcnt_r - LVLW'(1);
    end else if (cmd.accept) begin
      lcnt_r <= (in_level > LVLW'(MAX_LEVEL)) ? LVLW'(MAX_LEVEL) : in_level;
    end
    if (cmd.x_ld) begin
      x_r <= rd_q;
    end
    if (cmd.y_ld) begin
      y_r <= rd_q;
    end
    if (cmd.res_ld) begin
      res_r <= (m_r[3:0] == OPR_MUL) ? x_r * y_r : alu(m_r[3:0], x_r, y_r);
    end else if (cmd.res_div_ld) begin
      res_r <= (m_r[3:0] == OPR_DIV) ? div_quo : div_rem;
    end
  end

  // Per-instruction result flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      halt_r <= 1'b0;
      err_r  <= ERR_NONE;
    end else if (cmd.accept) begin
      ov_r   <= 1'b0;
      halt_r <= 1'b0;
      err_r  <= ERR_NONE;
    end else begin
      if (cmd.out_set) begin
        ov_r <= 1'b1;
      end
      if (cmd.halt_ld) begin
        halt_r <= 1'b1;
      end
      if (cmd.err_ld) begin
        err_r <= cmd.err_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      oval_r <= '0;
    end else if (cmd.out_set) begin
      oval_r <= rd_q;
    end
  end

  // Output register: holds one finished beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofull_r <= 1'b0;
    end else if (cmd.out_ld) begin
      ofull_r <= 1'b1;
    end else if (!out_stall) begin
      ofull_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_next_pc   <= pc_r;
      out_out_valid <= ov_r;
      out_out_value <= oval_r;
      out_halted    <= halt_r;
      out_error     <= err_r;
    end
  end

  assign out_valid = ofull_r;

  // Status toward the controller.
  always_comb begin
    sts.op        = op_r;
    sts.m_lo      = m_r[3:0];
    sts.m_hi_zero = m_r[31:4] == '0;
    sts.sp_full   = sp_r == SAW'(STACK_DEPTH - 1);
    sts.sp_ge1    = sp_r != '0;
    sts.sp_ge2    = sp_r > SAW'(1);
    sts.sp4_ok    = !sp_p4[SAW];
    sts.ret_ok    = bp_r != '0 && !bp_p3[SAW];
    sts.link_ok   = b_r != SAW'(STACK_DEPTH - 1);
    sts.rd_ok     = rd_q[31:SAW] == '0;
    sts.ea_ok     = ea_sum[32:SAW] == '0;
    sts.inc_ok    = inc_sum[32:SAW] == '0;
    sts.rd_zero   = rd_q == '0;
    sts.y_zero    = y_r == '0;
    sts.lvl_zero  = lcnt_r == '0;
    sts.div_done  = div_done;
    sts.out_free  = !ofull_r || !out_stall;
    sts.clr_last  = clr_r == SAW'(STACK_DEPTH - 1);
  end

endmodule

### sv/pl0_ctrl.sv
// ----------------------------------------------------------------------------
// PL/0 controller
// Sequences each instruction as memory reads, checks and writes.
// ----------------------------------------------------------------------------
module pl0_ctrl import pl0_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.addr_sel = A_SP;
    cmd.wd_sel   = WD_ZERO;
    cmd.sp_op    = SP_HOLD;
    cmd.pc_op    = PC_HOLD;
    cmd.bp_op    = BP_HOLD;
    cmd.err_code = ERR_NONE;
    in_stall     = 1'b1;

    unique case (state_r)
      S_CLEAR: begin
        cmd.addr_sel = A_CLR;
        cmd.wd_sel   = WD_ZERO;
        cmd.mem_wr   = 1'b1;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DEC;
        end
      end

      S_DEC: begin
        state_nxt = S_FIN;
        unique case (sts.op)
          OP_LIT: begin
            if (sts.sp_full) begin
              cmd.err_ld = 1'b1; cmd.err_code = ERR_RANGE;
            end else begin
              cmd.addr_sel = A_SPP1; cmd.wd_sel = WD_M; cmd.mem_wr = 1'b1;
              cmd.sp_op = SP_INC;
            end
          end
          OP_OPR: begin
            if (!sts.m_hi_zero) begin
              cmd.err_ld = 1'b1; cmd.err_code = ERR_OPR;
            end else begin
              case (sts.m_lo) inside
                OPR_RET: begin
                  if (!sts.ret_ok) begin
                    cmd.err_ld = 1'b1; cmd.err_code = ERR_RANGE;
                  end else begin
                    cmd.addr_sel = A_BP3; state_nxt = S_RET1;
                  end
                end
                OPR_NEG: begin
                  cmd.addr_sel = A_SP; state_nxt = S_NEG;
                end
                OPR_ODD: begin
                  if (!sts.sp_ge1) begin
                    cmd.err_ld = 1'b1; cmd.err_code = ERR_RANGE;
                  end else begin
                    cmd.addr_sel = A_SP; state_nxt = S_ODD;
                  end
                end
                OPR_ADD, OPR_SUB, OPR_MUL, OPR_DIV, OPR_MOD, OPR_EQL, OPR_NEQ,
                OPR_LSS, OPR_LEQ, OPR_GTR, OPR_GEQ: begin
                  if (!sts.sp_ge2) begin
                    cmd.err_ld = 1'b1; cmd.err_code = ERR_RANGE;
                  end else begin
                    cmd.addr_sel = A_SPM1; state_nxt = S_B1;
                  end
                end
                default: begin
                  cmd.err_ld = 1'b1; cmd.err_code = ERR_OPR;
                end
              endcase
            end
          end
          OP_LOD, OP_CAL: begin
            cmd.walk_init = 1'b1; state_nxt = S_WALK;
          end
          OP_STO: begin
            if (!sts.sp_ge1) begin
              cmd.err_ld = 1'b1; cmd.err_code = ERR_RANGE;
            end else begin
              cmd.walk_init = 1'b1; state_nxt = S_WALK;
            end
          end
          OP_INC: begin
            if (sts.inc_ok) begin
              cmd.sp_op = SP_ADDM;
            end else begin
              cmd.err_ld = 1'b1; cmd.err_code = ERR_RANGE;
            end
          end
          OP_JMP: cmd.pc_op = PC_M;
          OP_JPC: begin
            if (!sts.sp_ge1) begin
              cmd.err_ld = 1'b1; cmd.err_code = ERR_RANGE;
            end else begin
              cmd.addr_sel = A_SP; state_nxt = S_JPC;
            end
          end
          OP_SIO: begin
            if (sts.m_hi_zero && sts.m_lo == SIO_WRITE) begin
              if (!sts.sp_ge1) begin
                cmd.err_ld = 1'b1; cmd.err_code = ERR_RANGE;
              end else begin
                cmd.addr_sel = A_SP; state_nxt = S_SIO_W;
              end
            end else if (sts.m_hi_zero && sts.m_lo == SIO_READ) begin
              if (sts.sp_full) begin
                cmd.err_ld = 1'b1; cmd.err_code = ERR_RANGE;
              end else begin
                cmd.addr_sel = A_SPP1; cmd.wd_sel = WD_INV; cmd.mem_wr = 1'b1;
                cmd.sp_op = SP_INC;
              end
            end else if (sts.m_hi_zero && sts.m_lo == SIO_HALT) begin
              cmd.halt_ld = 1'b1;
            end else begin
              cmd.halt_ld = 1'b1; cmd.err_ld = 1'b1; cmd.err_code = ERR_SIO;
            end
          end
          default: begin
            cmd.err_ld = 1'b1; cmd.err_code = ERR_OPR;
          end
        endcase
      end

      // Static link walk, then the address phase of lod, sto and cal.
      S_WALK: begin
        if (!sts.lvl_zero) begin
          if (!sts.link_ok) begin
            cmd.err_ld = 1'b1; cmd.err_code = ERR_RANGE; state_nxt = S_FIN;
          end else begin
            cmd.addr_sel = A_LINK; state_nxt = S_WALK_CK;
          end
        end else if (sts.op == OP_LOD) begin
          if (!sts.ea_ok || sts.sp_full) begin
            cmd.err_ld = 1'b1; cmd.err_code = ERR_RANGE; state_nxt = S_FIN;
          end else begin
            cmd.addr_sel = A_EA; state_nxt = S_LOD_W;
          end
        end else if (sts.op == OP_STO) begin
          if (!sts.ea_ok) begin
            cmd.err_ld = 1'b1; cmd.err_code = ERR_RANGE; state_nxt = S_FIN;
          end else begin
            cmd.addr_sel = A_SP; state_nxt = S_STO_W;
          end
        end else begin
          if (!sts.sp4_ok) begin
            cmd.err_ld = 1'b1; cmd.err_code = ERR_RANGE; state_nxt = S_FIN;
          end else begin
            cmd.addr_sel = A_SPP1; cmd.wd_sel = WD_ZERO; cmd.mem_wr = 1'b1;
            state_nxt = S_CAL2;
          end
        end
      end

      S_WALK_CK: begin
        if (!sts.rd_ok) begin
          cmd.err_ld = 1'b1; cmd.err_code = ERR_RANGE; state_nxt = S_FIN;
        end else begin
          cmd.walk_step = 1'b1; state_nxt = S_WALK;
        end
      end

      S_LOD_W: begin
        cmd.addr_sel = A_SPP1; cmd.wd_sel = WD_RD; cmd.mem_wr = 1'b1;
        cmd.sp_op = SP_INC; state_nxt = S_FIN;
      end

      S_STO_W: begin
        cmd.addr_sel = A_EA; cmd.wd_sel = WD_RD; cmd.mem_wr = 1'b1;
        cmd.sp_op = SP_DEC; state_nxt = S_FIN;
      end

      // Call frame: static link, dynamic link, return address.
      S_CAL2: begin
        cmd.addr_sel = A_SPP2; cmd.wd_sel = WD_B; cmd.mem_wr = 1'b1;
        state_nxt = S_CAL3;
      end
      S_CAL3: begin
        cmd.addr_sel = A_SPP3; cmd.wd_sel = WD_BP; cmd.mem_wr = 1'b1;
        state_nxt = S_CAL4;
      end
      S_CAL4: begin
        cmd.addr_sel = A_SPP4; cmd.wd_sel = WD_PC; cmd.mem_wr = 1'b1;
        cmd.bp_op = BP_SPP1; cmd.pc_op = PC_M; state_nxt = S_FIN;
      end

      // Return: read return address, then dynamic link.
      S_RET1: begin
        cmd.x_ld = 1'b1; cmd.addr_sel = A_BP2; state_nxt = S_RET2;
      end
      S_RET2: begin
        state_nxt = S_FIN;
        if (!sts.rd_ok) begin
          cmd.err_ld = 1'b1; cmd.err_code = ERR_RANGE;
        end else begin
          cmd.sp_op = SP_RET; cmd.bp_op = BP_RD; cmd.pc_op = PC_X;
        end
      end

      S_NEG: begin
        cmd.addr_sel = A_SP; cmd.wd_sel = WD_NEG; cmd.mem_wr = 1'b1;
        state_nxt = S_FIN;
      end
      S_ODD: begin
        cmd.addr_sel = A_SP; cmd.wd_sel = WD_ODD; cmd.mem_wr = 1'b1;
        state_nxt = S_FIN;
      end

      // Binary operations: fetch both operands, compute, write back.
      S_B1: begin
        cmd.x_ld = 1'b1; cmd.addr_sel = A_SP; state_nxt = S_B2;
      end
      S_B2: begin
        cmd.y_ld = 1'b1; state_nxt = S_ALU;
      end
      S_ALU: begin
        if (sts.m_lo == OPR_DIV || sts.m_lo == OPR_MOD) begin
          if (sts.y_zero) begin
            cmd.err_ld = 1'b1; cmd.err_code = ERR_DIV0; state_nxt = S_FIN;
          end else begin
            cmd.div_start = 1'b1; state_nxt = S_DIV;
          end
        end else begin
          cmd.res_ld = 1'b1; state_nxt = S_WRB;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.res_div_ld = 1'b1; state_nxt = S_WRB;
        end
      end
      S_WRB: begin
        cmd.addr_sel = A_SPM1; cmd.wd_sel = WD_RES; cmd.mem_wr = 1'b1;
        cmd.sp_op = SP_DEC; state_nxt = S_FIN;
      end

      S_JPC: begin
        if (sts.rd_zero) begin
          cmd.pc_op = PC_M;
        end
        cmd.sp_op = SP_DEC; state_nxt = S_FIN;
      end

      S_SIO_W: begin
        cmd.out_set = 1'b1; cmd.sp_op = SP_DEC; state_nxt = S_FIN;
      end

      // Hand the result beat to the output register.
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1; state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
